// ----- design/msmf_pkg.sv -----
// ----------------------------------------------------------------------------
// msmf_pkg: shared types and constants of the marker span mute filter
// Holds the configuration register indexes, the engine state type and the
// payload structs that travel between the queues and the scan engine.
// ----------------------------------------------------------------------------
package msmf_pkg;

  localparam int unsigned MaxMarkerLenDef = 8;
  localparam int unsigned InQueueDepth    = 2;
  localparam int unsigned OutQueueDepth   = 4;
  localparam int unsigned MarkerW         = 64;
  localparam int unsigned LenW            = 4;
  localparam int unsigned CfgIdxW         = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartMarker = 3'd0,
    CfgStartLen    = 3'd1,
    CfgStopMarker  = 3'd2,
    CfgStopLen     = 3'd3,
    CfgBeginMuted  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    EngIdle,
    EngScan
  } eng_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       new_stream;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [MarkerW-1:0] start_marker;
    logic [MarkerW-1:0] stop_marker;
    logic               begin_muted;
  } marker_cfg_t;

endpackage

// ----- design/msmf_fifo.sv -----
// ----------------------------------------------------------------------------
// msmf_fifo: small register queue
// First-in first-out store with push/full on the write side and pop/empty on
// the read side; the head entry is always visible on data_o.
// ----------------------------------------------------------------------------
module msmf_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- design/msmf_engine.sv -----
// ----------------------------------------------------------------------------
// msmf_engine: marker scan engine
// Takes one byte from the input queue, appends it to the held bytes and then
// rescans them one step per cycle, a release waiting on a full result queue:
// drop a front marker, drop (muted) or release the oldest, stop on a prefix.
// ----------------------------------------------------------------------------
module msmf_engine #(
  parameter int unsigned MaxMarkerLen = msmf_pkg::MaxMarkerLenDef,
  localparam int unsigned CntW = $clog2(MaxMarkerLen + 1),
  localparam int unsigned IdxW = (MaxMarkerLen > 1) ? $clog2(MaxMarkerLen) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  msmf_pkg::marker_cfg_t cfg_i,
  input  logic [CntW-1:0]       start_len_i,
  input  logic [CntW-1:0]       stop_len_i,
  input  msmf_pkg::item_t       item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  output msmf_pkg::result_t     res_o,
  output logic                  res_push_o,
  input  logic                  res_full_i
);

  import msmf_pkg::*;

  eng_state_e      state_q, state_d;
  logic [7:0]      held_q [MaxMarkerLen];
  logic [7:0]      held_d [MaxMarkerLen];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            muted_q, muted_d;
  logic            pend_v_q, pend_v_d;
  logic [7:0]      pend_byte_q, pend_byte_d;

  logic [CntW-1:0] mlen;
  logic [7:0]      mbytes [MaxMarkerLen];
  logic            eq;
  logic            done;
  logic            hit0;

  // The watched marker depends on the mute state.
  assign mlen = muted_q ? stop_len_i : start_len_i;

  always_comb begin
    for (int j = 0; j < MaxMarkerLen; j++) begin
      mbytes[j] = muted_q ? cfg_i.stop_marker[8*j +: 8] : cfg_i.start_marker[8*j +: 8];
    end
  end

  // Compare the overlap of held bytes and marker, front aligned.
  always_comb begin
    eq = 1'b1;
    for (int j = 0; j < MaxMarkerLen; j++) begin
      if ((CntW'(j) < cnt_q) && (CntW'(j) < mlen) && (held_q[j] != mbytes[j])) begin
        eq = 1'b0;
      end
    end
  end

  assign done = (cnt_q == '0) || ((mlen != '0) && eq && (cnt_q < mlen));
  assign hit0 = (mlen != '0) && eq && (cnt_q >= mlen);

  always_comb begin
    logic [CntW-1:0] cnt_n;
    logic            muted_n;
    logic [CntW-1:0] drop;
    logic            do_shift;
    logic [CntW:0]   sum;

    cnt_n       = cnt_q;
    muted_n     = muted_q;
    drop        = '0;
    do_shift    = 1'b0;
    sum         = '0;
    state_d     = state_q;
    held_d      = held_q;
    cnt_d       = cnt_q;
    muted_d     = muted_q;
    pend_v_d    = pend_v_q;
    pend_byte_d = pend_byte_q;
    item_pop_o  = 1'b0;
    res_push_o  = 1'b0;
    res_o       = '0;

    unique case (state_q)
      EngIdle: begin
        if (!item_empty_i && !res_full_i) begin
          item_pop_o = 1'b1;
          cnt_n      = item_i.new_stream ? '0 : cnt_q;
          muted_n    = item_i.new_stream ? cfg_i.begin_muted : muted_q;
          cnt_d      = cnt_n;
          muted_d    = muted_n;
          if (muted_n && (stop_len_i == '0)) begin
            // Muted with no stop marker: the byte is dropped.
          end else if (!muted_n && (start_len_i == '0)) begin
            res_push_o = 1'b1;
            res_o.data = item_i.data;
            res_o.last = 1'b1;
          end else begin
            if (cnt_n < CntW'(MaxMarkerLen)) begin
              held_d[cnt_n[IdxW-1:0]] = item_i.data;
              cnt_d = CntW'(cnt_n + 1'b1);
            end
            state_d = EngScan;
          end
        end
      end
      EngScan: begin
        if (done) begin
          // The last released byte leaves with its end-of-run mark.
          if (!pend_v_q || !res_full_i) begin
            res_push_o = pend_v_q;
            res_o.data = pend_byte_q;
            res_o.last = 1'b1;
            pend_v_d   = 1'b0;
            state_d    = EngIdle;
          end
        end else if (hit0) begin
          drop     = mlen;
          do_shift = 1'b1;
          muted_d  = !muted_q;
        end else if (muted_q) begin
          drop     = CntW'(1);
          do_shift = 1'b1;
        end else if (!pend_v_q || !res_full_i) begin
          res_push_o  = pend_v_q;
          res_o.data  = pend_byte_q;
          res_o.last  = 1'b0;
          pend_v_d    = 1'b1;
          pend_byte_d = held_q[0];
          drop        = CntW'(1);
          do_shift    = 1'b1;
        end
      end
      default: state_d = EngIdle;
    endcase

    if (do_shift) begin
      for (int i = 0; i < MaxMarkerLen; i++) begin
        sum = (CntW + 1)'(i) + {1'b0, drop};
        if (sum < (CntW + 1)'(MaxMarkerLen)) begin
          held_d[i] = held_q[sum[IdxW-1:0]];
        end
      end
      cnt_d = CntW'(cnt_q - drop);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EngIdle;
      cnt_q    <= '0;
      muted_q  <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      muted_q  <= muted_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q      <= held_d;
    pend_byte_q <= pend_byte_d;
  end

endmodule

// ----- design/marker_span_mute_filter.sv -----
// ----------------------------------------------------------------------------
// marker_span_mute_filter: start/stop marker span suppression for byte streams
// A byte enters the input queue and is taken in by the engine. With no marker
// watched it goes straight to the result queue (or is dropped while muted);
// else the engine scans it step by step and then, in a closing step, pushes
// the last released byte with its end-of-run mark. Throughput: one byte per
// cycle when no marker is watched and the result queue has room; otherwise no
// new byte is taken until the scan of the last one is done.
// Reset clears the queues, the held count, the mute state and all configuration.
// ----------------------------------------------------------------------------
module marker_span_mute_filter #(
  parameter int unsigned MaxMarkerLen = msmf_pkg::MaxMarkerLenDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte_i,
  input  logic                          new_stream_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte_o,
  output logic                          last_of_run_o,
  input  logic                          cfg_we_i,
  input  logic [msmf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [msmf_pkg::MarkerW-1:0]  cfg_data_i
);

  import msmf_pkg::*;

  localparam int unsigned CntW = $clog2(MaxMarkerLen + 1);

  marker_cfg_t     cfg_q;
  logic [LenW-1:0] start_len_q;
  logic [LenW-1:0] stop_len_q;
  logic [CntW-1:0] start_len;
  logic [CntW-1:0] stop_len;

  item_t   in_item;
  item_t   eng_item;
  logic    eng_item_empty;
  logic    eng_item_pop;
  result_t eng_res;
  logic    eng_res_push;
  logic    eng_res_full;
  result_t out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      start_len_q <= '0;
      stop_len_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgStartMarker: cfg_q.start_marker <= cfg_data_i;
        CfgStartLen:    start_len_q        <= cfg_data_i[LenW-1:0];
        CfgStopMarker:  cfg_q.stop_marker  <= cfg_data_i;
        CfgStopLen:     stop_len_q         <= cfg_data_i[LenW-1:0];
        CfgBeginMuted:  cfg_q.begin_muted  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Lengths beyond the held store saturate at its depth.
  assign start_len = (start_len_q > LenW'(MaxMarkerLen)) ? CntW'(MaxMarkerLen)
                                                         : CntW'(start_len_q);
  assign stop_len  = (stop_len_q > LenW'(MaxMarkerLen))  ? CntW'(MaxMarkerLen)
                                                         : CntW'(stop_len_q);

  assign in_item.data       = in_byte_i;
  assign in_item.new_stream = new_stream_i;

  msmf_fifo #(
    .Width ($bits(item_t)),
    .Depth (InQueueDepth)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (in_item),
    .full_o  (full),
    .pop_i   (eng_item_pop),
    .data_o  (eng_item),
    .empty_o (eng_item_empty)
  );

  msmf_engine #(
    .MaxMarkerLen (MaxMarkerLen)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_len_i  (start_len),
    .stop_len_i   (stop_len),
    .item_i       (eng_item),
    .item_empty_i (eng_item_empty),
    .item_pop_o   (eng_item_pop),
    .res_o        (eng_res),
    .res_push_o   (eng_res_push),
    .res_full_i   (eng_res_full)
  );

  msmf_fifo #(
    .Width ($bits(result_t)),
    .Depth (OutQueueDepth)
  ) u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (eng_res_push),
    .data_i  (eng_res),
    .full_o  (eng_res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign out_byte_o    = out_res.data;
  assign last_of_run_o = out_res.last;

endmodule
